// File: sv/rbd_pkg.sv
// rbd_pkg: shared widths, limits and register codes for the 2x2 RGBA box downsampler.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int CHAN_W         = 8;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int MIN_SIZE       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1
    } t_cfg_reg;

    // One channel sum of two pixels, and four of them per line entry.
    typedef logic [CHAN_W:0] t_pair_sum;
    typedef t_pair_sum [3:0] t_pair_rgba;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0] [CHAN_W-1:0] t_rgba;

endpackage

// File: sv/rbd_pix_in_if.sv
// rbd_pix_in_if: valid/ready channel carrying one RGBA8 source pixel.
// Depends on rbd_pkg for the channel width.
`timescale 1ns / 1ps

interface rbd_pix_in_if import rbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// File: sv/rbd_pix_out_if.sv
// rbd_pix_out_if: valid/ready channel carrying one averaged RGBA8 pixel and its frame flag.
// Depends on rbd_pkg for the channel width.
`timescale 1ns / 1ps

interface rbd_pix_out_if import rbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              last_of_frame;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, last_of_frame,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_of_frame,
                    output ready);
endinterface

// File: sv/rgba_box_downsample_2x2_unit.sv
// rgba_box_downsample_2x2_unit: streaming 2x2 box filter producing the next mipmap level.
// Depends on rbd_pkg, rbd_pix_in_if and rbd_pix_out_if.
`timescale 1ns / 1ps
//
// Usage:
//   s_in takes source pixels in raster order, one word per accepted handshake.
//   m_out gives one averaged pixel per 2x2 block, at each odd column of each odd
//   row; last_of_frame marks the final output word of the reduced frame. An odd
//   last column or row produces nothing.
//   The config port writes source_width (index 0) or source_height (index 1);
//   values are clamped to [2, MAX_WIDTH] and [2, 4096], and any valid write
//   restarts the frame at row 0, column 0. Write only while the block is idle.
//   Throughput is one pixel per clock unless m_out stalls with the pipeline stage
//   and the output register both full: each pixel makes at most one access to the
//   line memory (a write of a pair sum on even rows, a read on odd rows, both at
//   odd columns only). An accepted pixel's result goes from the line memory read
//   into the pipeline stage, then through the add into the output register.
//   Reset sets both sizes to 2 and the position to row 0, column 0; the line
//   memory is not cleared, since each entry is written on an even row before
//   the row below reads it.
//   When m_out stalls, the result held in the pipeline stage waits behind the
//   output register and s_in drops ready only when both are full.
//
module rgba_box_downsample_2x2_unit
    import rbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    rbd_pix_in_if.sink            s_in,
    rbd_pix_out_if.source         m_out
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    // Largest width the config field can carry caps the clamp bound.
    localparam int W_CAP      = (MAX_WIDTH < (1 << CFG_W)) ? MAX_WIDTH : (1 << CFG_W) - 1;

    // Size registers, kept as last index and last even-pair end.
    logic [COL_W-1:0] r_col_max,  n_col_max;
    logic [COL_W-1:0] r_last_col, n_last_col;
    logic [ROW_W-1:0] r_row_max,  n_row_max;
    logic [ROW_W-1:0] r_last_row, n_last_row;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_rgba            r_left;

    // Line memory of pair sums.
    t_pair_rgba       r_line_mem [LINE_DEPTH];
    t_pair_rgba       r_rd_data;

    // Stage between memory read and output.
    logic             r_s1_v, n_s1_v;
    t_pair_rgba       r_s1_pair;
    logic             r_s1_last;

    logic             r_out_v, n_out_v;
    t_rgba            r_out_pix;
    logic             r_out_last;

    logic             in_accept;
    logic             cfg_hit;
    logic             out_free;
    logic             s1_move;
    logic             mem_we;
    logic             emit;
    logic [ADDR_W-1:0] slot;
    t_rgba            px;
    t_pair_rgba       pair_now;
    t_rgba            avg;
    logic [CFG_W:0]   w_clamp;
    logic [CFG_W:0]   h_clamp;

    assign px = {s_in.alpha_in, s_in.blue_in, s_in.green_in, s_in.red_in};

    assign out_free  = !r_out_v || m_out.ready;
    assign s1_move   = r_s1_v && out_free;
    assign s_in.ready = !r_s1_v || out_free;
    assign in_accept = s_in.valid && s_in.ready;

    assign slot   = ADDR_W'(r_col >> 1);
    assign mem_we = in_accept && r_col[0] && !r_row[0];
    assign emit   = in_accept && r_col[0] && r_row[0];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            pair_now[c] = {1'b0, r_left[c]} + {1'b0, px[c]};
        end
    end

    // Stored pair plus current pair, then drop two bits.
    always_comb begin
        logic [CHAN_W+1:0] s;
        for (int c = 0; c < 4; c++) begin
            s      = {1'b0, r_rd_data[c]} + {1'b0, r_s1_pair[c]};
            avg[c] = s[CHAN_W+1:2];
        end
    end

    // Clamp incoming sizes and derive the compare values.
    always_comb begin
        cfg_hit    = 1'b0;
        n_col_max  = r_col_max;
        n_last_col = r_last_col;
        n_row_max  = r_row_max;
        n_last_row = r_last_row;

        if ({1'b0, i_cfg_data} < (CFG_W+1)'(MIN_SIZE)) begin
            w_clamp = (CFG_W+1)'(MIN_SIZE);
        end else if ({1'b0, i_cfg_data} > (CFG_W+1)'(W_CAP)) begin
            w_clamp = (CFG_W+1)'(W_CAP);
        end else begin
            w_clamp = {1'b0, i_cfg_data};
        end

        if ({1'b0, i_cfg_data} < (CFG_W+1)'(MIN_SIZE)) begin
            h_clamp = (CFG_W+1)'(MIN_SIZE);
        end else if ({1'b0, i_cfg_data} > (CFG_W+1)'(MAX_HEIGHT)) begin
            h_clamp = (CFG_W+1)'(MAX_HEIGHT);
        end else begin
            h_clamp = {1'b0, i_cfg_data};
        end

        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SOURCE_WIDTH: begin
                    cfg_hit    = 1'b1;
                    n_col_max  = COL_W'(w_clamp - 1'b1);
                    n_last_col = COL_W'({w_clamp[CFG_W:1], 1'b0} - 1'b1);
                end
                CFG_SOURCE_HEIGHT: begin
                    cfg_hit    = 1'b1;
                    n_row_max  = ROW_W'(h_clamp - 1'b1);
                    n_last_row = ROW_W'({h_clamp[CFG_W:1], 1'b0} - 1'b1);
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Position counters and pipeline valids.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_accept) begin
            if (r_col == r_col_max) begin
                n_col = '0;
                n_row = (r_row == r_row_max) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end

        if (emit) begin
            n_s1_v = 1'b1;
        end else if (s1_move) begin
            n_s1_v = 1'b0;
        end else begin
            n_s1_v = r_s1_v;
        end

        if (s1_move) begin
            n_out_v = 1'b1;
        end else if (m_out.ready) begin
            n_out_v = 1'b0;
        end else begin
            n_out_v = r_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_max  <= COL_W'(MIN_SIZE - 1);
            r_last_col <= COL_W'(MIN_SIZE - 1);
            r_row_max  <= ROW_W'(MIN_SIZE - 1);
            r_last_row <= ROW_W'(MIN_SIZE - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_s1_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_col_max  <= n_col_max;
            r_last_col <= n_last_col;
            r_row_max  <= n_row_max;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_v     <= n_s1_v;
            r_out_v    <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept && !r_col[0]) begin
            r_left <= px;
        end
        if (emit) begin
            r_s1_pair <= pair_now;
            r_s1_last <= (r_col == r_last_col) && (r_row == r_last_row);
        end
        if (s1_move) begin
            r_out_pix  <= avg;
            r_out_last <= r_s1_last;
        end
    end

    // Line memory: at most one access per pixel; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[slot] <= pair_now;
        end
        if (emit) begin
            r_rd_data <= r_line_mem[slot];
        end
    end

    assign m_out.valid         = r_out_v;
    assign m_out.red_out       = r_out_pix[0];
    assign m_out.green_out     = r_out_pix[1];
    assign m_out.blue_out      = r_out_pix[2];
    assign m_out.alpha_out     = r_out_pix[3];
    assign m_out.last_of_frame = r_out_last;

endmodule

// File: sv/rbd_checker.sv
// rbd_checker: port-level checks for rgba_box_downsample_2x2_unit, with its bind.
// Depends on rbd_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps

module rbd_checker
    import rbd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAN_W-1:0] i_out_red,
    input logic [CHAN_W-1:0] i_out_green,
    input logic [CHAN_W-1:0] i_out_blue,
    input logic [CHAN_W-1:0] i_out_alpha,
    input logic              i_out_last
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue) &&
             $stable(i_out_alpha) && $stable(i_out_last)))
        else $error("output word changed while stalled");

    // A new output word follows an accepted pixel through the stage and output registers.
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("output word without a preceding input word");

    // With the output register empty the pipeline cannot be full.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind rgba_box_downsample_2x2_unit rbd_checker u_rbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_in.valid),
    .i_in_ready  (s_in.ready),
    .i_out_valid (m_out.valid),
    .i_out_ready (m_out.ready),
    .i_out_red   (m_out.red_out),
    .i_out_green (m_out.green_out),
    .i_out_blue  (m_out.blue_out),
    .i_out_alpha (m_out.alpha_out),
    .i_out_last  (m_out.last_of_frame)
);

// File: test/rgba_box_downsample_2x2_unit_tb.sv
// rgba_box_downsample_2x2_unit_tb: streams RGBA8 frames of many sizes through the 2x2 box
// downsampler and checks every averaged word against a cycle-free mipmap predictor.
// Depends on rbd_pkg, rbd_pix_in_if, rbd_pix_out_if and rgba_box_downsample_2x2_unit.
`timescale 1ns / 1ps

module rgba_box_downsample_2x2_unit_tb;
    import rbd_pkg::*;

    localparam int          LINE_SLOTS   = DEF_MAX_WIDTH / 2;
    localparam int          RANDOM_WORDS = 1200;
    localparam int          SETTLE       = 4;     // covers the stage and output registers plus margin
    localparam int          QUIET_LIMIT  = 1000;
    localparam int          REPORT_MAX   = 20;
    // indexes past the register map: a write there must not touch the frame
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [3:0][CHAN_W-1:0] t_rgba8;
    typedef struct packed {
        t_rgba8 rgba;
        logic   last;
    } t_mip_pixel;

    const string chan_name [4] = '{"red_out", "green_out", "blue_out", "alpha_out"};

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 src_valid = 1'b0;
    t_rgba8               src_pix   = '0;
    logic                 sink_ready = 1'b0;

    rbd_pix_in_if  s_in ();
    rbd_pix_out_if m_out ();

    assign s_in.valid    = src_valid;
    assign s_in.red_in   = src_pix[0];
    assign s_in.green_in = src_pix[1];
    assign s_in.blue_in  = src_pix[2];
    assign s_in.alpha_in = src_pix[3];
    assign m_out.ready   = sink_ready;

    rgba_box_downsample_2x2_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .s_in        (s_in),
        .m_out       (m_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor state
    t_pair_rgba       pair_line [LINE_SLOTS];
    t_rgba8           held_left  = '0;
    int unsigned      col_pos    = 0;
    int unsigned      row_pos    = 0;
    logic [CFG_W-1:0] width_reg  = CFG_W'(MIN_SIZE);
    logic [CFG_W-1:0] height_reg = CFG_W'(MIN_SIZE);

    t_mip_pixel  mip_expected [$];
    t_rgba8      pixel_q [$];
    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_pct     = 0;
    int unsigned src_gap      = 0;
    int unsigned sink_stall   = 0;
    int unsigned quiet_cycles = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Advance the source position by one pixel and queue the averaged word it completes.
    task automatic predict_mip(input t_rgba8 px);
        int unsigned w, h, slot, last_col, last_row;
        logic [CHAN_W+1:0] total;
        t_mip_pixel res;
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        slot = col_pos >> 1;
        if (col_pos[0] == 1'b0) begin
            held_left = px;
        end else if (row_pos[0] == 1'b0) begin
            for (int c = 0; c < 4; c++)
                pair_line[slot][c] = {1'b0, held_left[c]} + {1'b0, px[c]};
        end else begin
            last_col = (w & ~32'd1) - 1;
            last_row = (h & ~32'd1) - 1;
            for (int c = 0; c < 4; c++) begin
                total = {1'b0, pair_line[slot][c]} + {2'b00, held_left[c]} + {2'b00, px[c]};
                res.rgba[c] = total[CHAN_W+1:2];
            end
            res.last = (col_pos == last_col) && (row_pos == last_row);
            mip_expected = {mip_expected, res};
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (src_valid && s_in.ready) begin
                predict_mip(src_pix);
                words_taken++;
            end
            if (!src_valid || s_in.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    src_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    src_pix   <= pixel_q.pop_front();
                    src_valid <= 1'b1;
                    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                        src_gap = $urandom_range(1, 11);
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_mip_pixel want;
        t_mip_pixel got;
        if (i_rst_n) begin
            if (m_out.valid && sink_ready) begin
                got.rgba = {m_out.alpha_out, m_out.blue_out, m_out.green_out, m_out.red_out};
                got.last = m_out.last_of_frame;
                if (mip_expected.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: unexpected output word, expected none, got %h",
                                 $time, got);
                    mismatches++;
                end else begin
                    want = mip_expected.pop_front();
                    for (int c = 0; c < 4; c++) begin
                        if (got.rgba[c] !== want.rgba[c]) begin
                            if (mismatches < REPORT_MAX)
                                $display("%0t: %s expected %0d, got %0d", $time,
                                         chan_name[c], want.rgba[c], got.rgba[c]);
                            mismatches++;
                        end
                    end
                    if (got.last !== want.last) begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t: last_of_frame expected %0d, got %0d", $time,
                                     want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (sink_stall != 0) begin
                sink_stall--;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    sink_stall = $urandom_range(1, 11);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((src_valid && s_in.ready) || (m_out.valid && sink_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("** rgba_box_downsample_2x2_unit: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic t_rgba8 rgba(input int r, input int g, input int b, input int a);
        rgba = {CHAN_W'(a), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
    endfunction

    function automatic t_rgba8 random_pixel();
        t_rgba8 px;
        for (int c = 0; c < 4; c++) begin
            case ($urandom_range(0, 7))
                0:       px[c] = '0;
                1:       px[c] = '1;
                default: px[c] = CHAN_W'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic push_pixel(input t_rgba8 px);
        pixel_q = {pixel_q, px};
        words_queued++;
    endtask

    task automatic send_pixels(input int unsigned n);
        repeat (n) push_pixel(random_pixel());
    endtask

    // Hold until every queued word is taken and every averaged word has come back.
    task automatic wait_results();
        while (words_taken != words_queued || mip_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SOURCE_WIDTH) begin
            width_reg = val;
        end else if (idx == CFG_SOURCE_HEIGHT) begin
            height_reg = val;
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    initial begin
        int unsigned w, h, frame, n, random_total, phase;
        random_total = 0;
        phase = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes: one 2x2 block with saturated, zero and truncated channels.
        idle_pct = 20;
        push_pixel(rgba(255, 0, 255, 1));
        push_pixel(rgba(255, 0, 255, 1));
        push_pixel(rgba(255, 0, 255, 1));
        push_pixel(rgba(255, 0, 254, 0));
        drain();

        // Odd last column and odd last row are dropped.
        write_reg(CFG_SOURCE_WIDTH, CFG_W'(3));
        write_reg(CFG_SOURCE_HEIGHT, CFG_W'(3));
        send_pixels(9);
        drain();

        // Sizes below the minimum clamp up to 2.
        write_reg(CFG_SOURCE_WIDTH, CFG_W'(0));
        write_reg(CFG_SOURCE_HEIGHT, CFG_W'(1));
        send_pixels(4);
        drain();

        // A write past the register map leaves the frame position alone.
        write_reg(CFG_SOURCE_WIDTH, CFG_W'(4));
        write_reg(CFG_SOURCE_HEIGHT, CFG_W'(2));
        send_pixels(6);
        drain();
        write_reg(CFG_SPARE_B, '1);
        send_pixels(2);
        drain();

        // Sizes above the maximum clamp down; send part of the first row only.
        idle_pct = 5;
        write_reg(CFG_SOURCE_WIDTH, '1);
        write_reg(CFG_SOURCE_HEIGHT, '1);
        send_pixels(64);
        drain();

        while (random_total < RANDOM_WORDS) begin
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 10);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 6);
            write_reg(CFG_SOURCE_WIDTH, CFG_W'(w));
            write_reg(CFG_SOURCE_HEIGHT, CFG_W'(h));
            frame = w * h;
            case ((phase == 0) ? 2 : $urandom_range(0, 6))
                0: begin
                    // partial frame, a stray write, then the rest of the frame
                    n = $urandom_range(1, frame - 1);
                    send_pixels(n);
                    drain();
                    write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                              CFG_W'($urandom));
                    send_pixels(frame - n);
                    random_total += frame;
                end
                1: begin
                    // abandon the frame part way; the next phase restarts it
                    n = $urandom_range(1, frame - 1);
                    send_pixels(n);
                    random_total += n;
                end
                2: begin
                    // stop sending until every pending result is out
                    n = $urandom_range(1, frame - 1);
                    send_pixels(n);
                    wait_results();
                    send_pixels(frame - n);
                    random_total += frame;
                end
                default: begin
                    n = frame * $urandom_range(1, 3);
                    send_pixels(n);
                    random_total += n;
                end
            endcase
            drain();
            phase++;
        end

        // Closing stretch at full rate on both sides.
        idle_pct = 0;
        write_reg(CFG_SOURCE_WIDTH, CFG_W'(16));
        write_reg(CFG_SOURCE_HEIGHT, CFG_W'(4));
        send_pixels(2 * 16 * 4);
        drain();

        if (mismatches == 0 && mip_expected.size() == 0) begin
            $display("** rgba_box_downsample_2x2_unit: PASSED **");
        end else begin
            $display("** rgba_box_downsample_2x2_unit: FAILED **");
        end
        $finish;
    end

endmodule
